>>> hw/rtl/ffa_pkg.sv
// Shared types, constants and the microcode program of the first-fit heap allocator.
`default_nettype none

package ffa_pkg;

  localparam int unsigned HEAP_BYTES   = 1024;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ALIGN_BYTES  = 8;

  localparam int unsigned ADDR_W  = $clog2(HEAP_BYTES);
  localparam int unsigned REQ_W   = 11;
  localparam int unsigned NEED_W  = REQ_W + 1;
  localparam int unsigned SPL_W   = NEED_W + 1;
  localparam int unsigned BSZ_W   = ADDR_W;
  localparam int unsigned STEP_W  = ADDR_W + 1;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned UPC_W   = 5;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [UPC_W-1:0]  upc_t;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd2;

  // Microprogram step addresses
  localparam upc_t S_IDLE        = 5'd0;
  localparam upc_t S_I_CHK       = 5'd1;
  localparam upc_t S_I_DO        = 5'd2;
  localparam upc_t S_A_CHK       = 5'd3;
  localparam upc_t S_A_RD        = 5'd4;
  localparam upc_t S_A_TST       = 5'd5;
  localparam upc_t S_A_ADV       = 5'd6;
  localparam upc_t S_A_SPL       = 5'd7;
  localparam upc_t S_A_WHOLE     = 5'd8;
  localparam upc_t S_A_SPLIT_HDR = 5'd9;
  localparam upc_t S_A_SPLIT_FIX = 5'd10;
  localparam upc_t S_E_ALLOC     = 5'd11;
  localparam upc_t S_F_CHK       = 5'd12;
  localparam upc_t S_F_DO        = 5'd13;
  localparam upc_t S_E_OK        = 5'd14;
  localparam upc_t S_E_BAD       = 5'd15;
  localparam upc_t S_E_NOFIT     = 5'd16;

  typedef enum logic [3:0] {
    A_NONE,
    A_LATCH,
    A_INIT,
    A_READ,
    A_ADVANCE,
    A_UNLINK,
    A_SPLIT_HDR,
    A_SPLIT_FIX,
    A_FREE,
    A_EMIT_ALLOC,
    A_EMIT_OK,
    A_EMIT_BAD,
    A_EMIT_NOFIT
  } act_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_INIT_BAD,
    C_ALLOC_ZERO,
    C_WALK_END,
    C_FITS,
    C_SPLIT_OK,
    C_FREE_BAD,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    logic  hold;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic             in_acc;
    logic [CMD_W-1:0] cmd;
    logic             init_bad;
    logic             alloc_zero;
    logic             walk_end;
    logic             fits;
    logic             split_ok;
    logic             free_bad;
    logic             out_free;
  } flags_t;

  typedef struct packed {
    act_e act;
    logic idle;
  } ctl_t;

  typedef struct packed {
    logic  has_next;
    addr_t next;
  } link_t;

  typedef struct packed {
    logic             rd_en;
    addr_t            rd_addr;
    logic             size_we;
    addr_t            size_addr;
    logic [BSZ_W-1:0] size_data;
    logic             link_we;
    addr_t            link_addr;
    link_t            link_data;
  } mem_req_t;

  // Jump is taken when the condition holds; otherwise hold in place or fall through.
  function automatic uword_t ucode(upc_t upc);
    uword_t w;
    w = '{act: A_NONE, cond: C_ALWAYS, hold: 1'b0, target: S_IDLE};
    case (upc)
      S_IDLE:        w = '{act: A_LATCH,      cond: C_DISPATCH,   hold: 1'b1, target: S_IDLE};
      S_I_CHK:       w = '{act: A_NONE,       cond: C_INIT_BAD,   hold: 1'b0, target: S_E_BAD};
      S_I_DO:        w = '{act: A_INIT,       cond: C_ALWAYS,     hold: 1'b0, target: S_E_OK};
      S_A_CHK:       w = '{act: A_NONE,       cond: C_ALLOC_ZERO, hold: 1'b0, target: S_E_BAD};
      S_A_RD:        w = '{act: A_READ,       cond: C_WALK_END,   hold: 1'b0, target: S_E_NOFIT};
      S_A_TST:       w = '{act: A_NONE,       cond: C_FITS,       hold: 1'b0, target: S_A_SPL};
      S_A_ADV:       w = '{act: A_ADVANCE,    cond: C_ALWAYS,     hold: 1'b0, target: S_A_RD};
      S_A_SPL:       w = '{act: A_NONE,       cond: C_SPLIT_OK,   hold: 1'b0,
                           target: S_A_SPLIT_HDR};
      S_A_WHOLE:     w = '{act: A_UNLINK,     cond: C_ALWAYS,     hold: 1'b0, target: S_E_ALLOC};
      S_A_SPLIT_HDR: w = '{act: A_SPLIT_HDR,  cond: C_ALWAYS,     hold: 1'b0,
                           target: S_A_SPLIT_FIX};
      S_A_SPLIT_FIX: w = '{act: A_SPLIT_FIX,  cond: C_ALWAYS,     hold: 1'b0, target: S_E_ALLOC};
      S_E_ALLOC:     w = '{act: A_EMIT_ALLOC, cond: C_OUT_FREE,   hold: 1'b1, target: S_IDLE};
      S_F_CHK:       w = '{act: A_NONE,       cond: C_FREE_BAD,   hold: 1'b0, target: S_E_BAD};
      S_F_DO:        w = '{act: A_FREE,       cond: C_ALWAYS,     hold: 1'b0, target: S_E_OK};
      S_E_OK:        w = '{act: A_EMIT_OK,    cond: C_OUT_FREE,   hold: 1'b1, target: S_IDLE};
      S_E_BAD:       w = '{act: A_EMIT_BAD,   cond: C_OUT_FREE,   hold: 1'b1, target: S_IDLE};
      S_E_NOFIT:     w = '{act: A_EMIT_NOFIT, cond: C_OUT_FREE,   hold: 1'b1, target: S_IDLE};
      default:       w = '{act: A_NONE,       cond: C_ALWAYS,     hold: 1'b0, target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ffa_hdr_mem.sv
// Block header store: size array and link array, one write port each, registered read.
`default_nettype none

module ffa_hdr_mem (
  input  wire logic                           clk_i,
  input  wire ffa_pkg::mem_req_t              req_i,
  output logic [ffa_pkg::BSZ_W-1:0]           size_rd_o,
  output ffa_pkg::link_t                      link_rd_o
);

  logic [ffa_pkg::BSZ_W-1:0] size_mem [ffa_pkg::HEAP_BYTES];
  ffa_pkg::link_t            link_mem [ffa_pkg::HEAP_BYTES];
  logic [ffa_pkg::BSZ_W-1:0] size_rd_q;
  ffa_pkg::link_t            link_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.size_we) begin
      size_mem[req_i.size_addr] <= req_i.size_data;
    end
    if (req_i.link_we) begin
      link_mem[req_i.link_addr] <= req_i.link_data;
    end
    if (req_i.rd_en) begin
      size_rd_q <= size_mem[req_i.rd_addr];
      link_rd_q <= link_mem[req_i.rd_addr];
    end
  end

  assign size_rd_o = size_rd_q;
  assign link_rd_o = link_rd_q;

endmodule

`default_nettype wire

>>> hw/rtl/ffa_sequencer.sv
// Microcode sequencer: step counter, program ROM and condition select.
`default_nettype none

module ffa_sequencer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ffa_pkg::flags_t flags_i,
  output ffa_pkg::ctl_t        ctl_o
);

  ffa_pkg::upc_t   upc_q, upc_d;
  ffa_pkg::uword_t uw;
  ffa_pkg::upc_t   disp_tgt;
  logic            cond_true;

  assign uw = ffa_pkg::ucode(upc_q);

  always_comb begin
    case (uw.cond)
      ffa_pkg::C_ALWAYS:     cond_true = 1'b1;
      ffa_pkg::C_DISPATCH:   cond_true = flags_i.in_acc;
      ffa_pkg::C_INIT_BAD:   cond_true = flags_i.init_bad;
      ffa_pkg::C_ALLOC_ZERO: cond_true = flags_i.alloc_zero;
      ffa_pkg::C_WALK_END:   cond_true = flags_i.walk_end;
      ffa_pkg::C_FITS:       cond_true = flags_i.fits;
      ffa_pkg::C_SPLIT_OK:   cond_true = flags_i.split_ok;
      ffa_pkg::C_FREE_BAD:   cond_true = flags_i.free_bad;
      ffa_pkg::C_OUT_FREE:   cond_true = flags_i.out_free;
      default:               cond_true = 1'b0;
    endcase
  end

  always_comb begin
    case (flags_i.cmd)
      ffa_pkg::CMD_INIT:  disp_tgt = ffa_pkg::S_I_CHK;
      ffa_pkg::CMD_ALLOC: disp_tgt = ffa_pkg::S_A_CHK;
      ffa_pkg::CMD_FREE:  disp_tgt = ffa_pkg::S_F_CHK;
      default:            disp_tgt = ffa_pkg::S_E_BAD;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      upc_d = (uw.cond == ffa_pkg::C_DISPATCH) ? disp_tgt : uw.target;
    end else if (uw.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + ffa_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ffa_pkg::S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // A holding step performs its action only in the cycle it moves on.
  assign ctl_o.act  = (!uw.hold || cond_true) ? uw.act : ffa_pkg::A_NONE;
  assign ctl_o.idle = (uw.cond == ffa_pkg::C_DISPATCH);

endmodule

`default_nettype wire

>>> hw/rtl/ffa_datapath.sv
// Allocator datapath: request latches, list walk registers, header writes and result register.
`default_nettype none

module ffa_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ffa_pkg::ctl_t              ctl_i,
  input  wire logic                       in_acc_i,
  input  wire logic [ffa_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [ffa_pkg::REQ_W-1:0]  req_i,
  input  wire ffa_pkg::addr_t             faddr_i,
  input  wire logic [ffa_pkg::BSZ_W-1:0]  size_rd_i,
  input  wire ffa_pkg::link_t             link_rd_i,
  input  wire logic                       out_ready_i,
  output ffa_pkg::flags_t                 flags_o,
  output ffa_pkg::mem_req_t               mem_o,
  output logic                            out_valid_o,
  output ffa_pkg::addr_t                  out_addr_o,
  output logic [ffa_pkg::ST_W-1:0]        out_status_o
);

  localparam logic [ffa_pkg::NEED_W-1:0] AlignMask = ffa_pkg::NEED_W'(ffa_pkg::ALIGN_BYTES - 1);

  // Control state
  logic                         head_valid_q, head_valid_d;
  logic                         out_valid_q, out_valid_d;
  // Payload
  ffa_pkg::addr_t               head_q, head_d;
  logic [ffa_pkg::REQ_W-1:0]    req_q;
  logic [ffa_pkg::NEED_W-1:0]   need_q;
  ffa_pkg::addr_t               faddr_q;
  ffa_pkg::addr_t               cur_q, cur_d;
  logic                         cur_valid_q, cur_valid_d;
  ffa_pkg::addr_t               prev_q, prev_d;
  logic                         at_head_q, at_head_d;
  logic [ffa_pkg::STEP_W-1:0]   steps_q, steps_d;
  ffa_pkg::addr_t               out_addr_q, out_addr_d;
  logic [ffa_pkg::ST_W-1:0]     out_status_q, out_status_d;

  logic [ffa_pkg::NEED_W-1:0]   need_in;
  logic [ffa_pkg::REQ_W-1:0]    init_sz;
  logic [ffa_pkg::NEED_W-1:0]   size_ext;
  logic [ffa_pkg::SPL_W-1:0]    split_sum;
  ffa_pkg::addr_t               split_addr;
  ffa_pkg::addr_t               free_hdr;
  ffa_pkg::addr_t               data_addr;
  logic                         out_free;

  assign need_in  = (ffa_pkg::NEED_W'(req_i) + AlignMask) & ~AlignMask;
  assign init_sz  = (req_q > ffa_pkg::REQ_W'(ffa_pkg::HEAP_BYTES))
                  ? ffa_pkg::REQ_W'(ffa_pkg::HEAP_BYTES) : req_q;
  assign size_ext = ffa_pkg::NEED_W'(size_rd_i);
  assign split_sum = ffa_pkg::SPL_W'(cur_q) + ffa_pkg::SPL_W'(ffa_pkg::HEADER_BYTES)
                   + ffa_pkg::SPL_W'(need_q);
  assign split_addr = split_sum[ffa_pkg::ADDR_W-1:0];
  // A 10-bit data offset minus one header always lands inside the heap.
  assign free_hdr   = faddr_q - ffa_pkg::ADDR_W'(ffa_pkg::HEADER_BYTES);
  assign data_addr  = cur_q + ffa_pkg::ADDR_W'(ffa_pkg::HEADER_BYTES);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    flags_o.in_acc     = in_acc_i;
    flags_o.cmd        = cmd_i;
    flags_o.init_bad   = init_sz <= ffa_pkg::REQ_W'(ffa_pkg::HEADER_BYTES);
    flags_o.alloc_zero = req_q == '0;
    flags_o.walk_end   = !cur_valid_q || (steps_q == ffa_pkg::STEP_W'(ffa_pkg::HEAP_BYTES));
    flags_o.fits       = size_ext >= need_q;
    flags_o.split_ok   = (size_ext > need_q + ffa_pkg::NEED_W'(ffa_pkg::HEADER_BYTES))
                      && (split_sum < ffa_pkg::SPL_W'(ffa_pkg::HEAP_BYTES));
    flags_o.free_bad   = faddr_q < ffa_pkg::ADDR_W'(ffa_pkg::HEADER_BYTES);
    flags_o.out_free   = out_free;
  end

  always_comb begin
    mem_o        = '0;
    mem_o.rd_addr = cur_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    prev_d       = prev_q;
    at_head_d    = at_head_q;
    steps_d      = steps_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    case (ctl_i.act)
      ffa_pkg::A_LATCH: begin
        cur_d       = head_q;
        cur_valid_d = head_valid_q;
        at_head_d   = 1'b1;
        steps_d     = '0;
      end
      ffa_pkg::A_INIT: begin
        mem_o.size_we   = 1'b1;
        mem_o.size_addr = '0;
        mem_o.size_data = ffa_pkg::BSZ_W'(init_sz - ffa_pkg::REQ_W'(ffa_pkg::HEADER_BYTES));
        mem_o.link_we   = 1'b1;
        mem_o.link_addr = '0;
        mem_o.link_data = '0;
        head_d          = '0;
        head_valid_d    = 1'b1;
      end
      ffa_pkg::A_READ: begin
        mem_o.rd_en = 1'b1;
      end
      ffa_pkg::A_ADVANCE: begin
        prev_d      = cur_q;
        at_head_d   = 1'b0;
        cur_valid_d = link_rd_i.has_next;
        cur_d       = link_rd_i.next;
        steps_d     = steps_q + ffa_pkg::STEP_W'(1);
      end
      ffa_pkg::A_UNLINK: begin
        if (at_head_q) begin
          head_d       = link_rd_i.next;
          head_valid_d = link_rd_i.has_next;
        end else begin
          mem_o.link_we   = 1'b1;
          mem_o.link_addr = prev_q;
          mem_o.link_data = link_rd_i;
        end
      end
      ffa_pkg::A_SPLIT_HDR: begin
        mem_o.size_we   = 1'b1;
        mem_o.size_addr = split_addr;
        mem_o.size_data = ffa_pkg::BSZ_W'(size_ext - need_q
                          - ffa_pkg::NEED_W'(ffa_pkg::HEADER_BYTES));
        mem_o.link_we   = 1'b1;
        mem_o.link_addr = split_addr;
        mem_o.link_data = link_rd_i;
      end
      ffa_pkg::A_SPLIT_FIX: begin
        mem_o.size_we   = 1'b1;
        mem_o.size_addr = cur_q;
        mem_o.size_data = ffa_pkg::BSZ_W'(need_q);
        if (at_head_q) begin
          head_d       = split_addr;
          head_valid_d = 1'b1;
        end else begin
          mem_o.link_we   = 1'b1;
          mem_o.link_addr = prev_q;
          mem_o.link_data = '{has_next: 1'b1, next: split_addr};
        end
      end
      ffa_pkg::A_FREE: begin
        mem_o.link_we   = 1'b1;
        mem_o.link_addr = free_hdr;
        mem_o.link_data = '{has_next: head_valid_q, next: head_q};
        head_d          = free_hdr;
        head_valid_d    = 1'b1;
      end
      ffa_pkg::A_EMIT_ALLOC: begin
        out_valid_d  = 1'b1;
        out_addr_d   = data_addr;
        out_status_d = ffa_pkg::ST_OK;
      end
      ffa_pkg::A_EMIT_OK: begin
        out_valid_d  = 1'b1;
        out_addr_d   = '0;
        out_status_d = ffa_pkg::ST_OK;
      end
      ffa_pkg::A_EMIT_BAD: begin
        out_valid_d  = 1'b1;
        out_addr_d   = '0;
        out_status_d = ffa_pkg::ST_BAD;
      end
      ffa_pkg::A_EMIT_NOFIT: begin
        out_valid_d  = 1'b1;
        out_addr_d   = '0;
        out_status_d = ffa_pkg::ST_NOFIT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.act == ffa_pkg::A_LATCH) begin
      req_q   <= req_i;
      need_q  <= need_in;
      faddr_q <= faddr_i;
    end
    head_q       <= head_d;
    cur_q        <= cur_d;
    cur_valid_q  <= cur_valid_d;
    prev_q       <= prev_d;
    at_head_q    <= at_head_d;
    steps_q      <= steps_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

>>> hw/rtl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: sequencer, datapath and header store.
//
// One request per command is taken when s_axis_tready is high (the sequencer is at its
// dispatch step) and gives exactly one result. Init and free run a check, a work and a
// result step; a bad size or free address skips from its check, an unknown command from
// dispatch, to the result step. An allocate checks its size, then reads and tests free
// blocks and unlinks the first that fits whole or splits it (header write, then size fix)
// before its result step; a failed walk ends in one too. The walk is bounded by one
// header read per block through the single read port of the header store, and stops
// after HEAP_BYTES headers. A result waits in an output register, so a stalled master side
// delays only the next result step. The header store is not cleared after reset.
`default_nettype none

module first_fit_heap_allocator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [10:0] request_size, [20:11] free_address
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [9:0] data_address
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  ffa_pkg::ctl_t                 ctl;
  ffa_pkg::flags_t               flags;
  ffa_pkg::mem_req_t             mem_req;
  logic [ffa_pkg::BSZ_W-1:0]     size_rd;
  ffa_pkg::link_t                link_rd;
  ffa_pkg::addr_t                out_addr;
  logic                          in_acc;
  logic                          emit;

  assign s_axis_tready = ctl.idle;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  ffa_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  ffa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .in_acc_i     (in_acc),
    .cmd_i        (s_axis_tuser),
    .req_i        (s_axis_tdata[10:0]),
    .faddr_i      (s_axis_tdata[20:11]),
    .size_rd_i    (size_rd),
    .link_rd_i    (link_rd),
    .out_ready_i  (m_axis_tready),
    .flags_o      (flags),
    .mem_o        (mem_req),
    .out_valid_o  (m_axis_tvalid),
    .out_addr_o   (out_addr),
    .out_status_o (m_axis_tuser)
  );

  ffa_hdr_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .size_rd_o (size_rd),
    .link_rd_o (link_rd)
  );

  assign m_axis_tdata = {6'b0, out_addr};

  assign emit = (ctl.act == ffa_pkg::A_EMIT_ALLOC) || (ctl.act == ffa_pkg::A_EMIT_OK)
             || (ctl.act == ffa_pkg::A_EMIT_BAD) || (ctl.act == ffa_pkg::A_EMIT_NOFIT);

  // A taken request keeps the input side closed until its result is written.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input accepted again right after a request");

  // Results are written only into a free output register.
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over a pending result");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid)
    else $error("written result not presented");

  // The header store is never touched while waiting for a request.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!mem_req.size_we && !mem_req.link_we))
    else $error("header write while idle");

endmodule

`default_nettype wire

>>> tb/tb_first_fit_heap_allocator_top.sv
// Self-checking testbench for the first-fit heap allocator: random requests, checked replies.
`default_nettype none

module tb_first_fit_heap_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ffa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned N_RANDOM     = 1275;
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_PAUSE  = 600;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned CYCLE_LIMIT  = 20000000;

  typedef struct packed {
    logic [ffa_pkg::CMD_W-1:0] cmd;
    logic [ffa_pkg::REQ_W-1:0] size;
    ffa_pkg::addr_t            faddr;
  } heap_req_t;

  typedef struct packed {
    ffa_pkg::addr_t           addr;
    logic [ffa_pkg::ST_W-1:0] status;
  } heap_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [10:0] request_size, [20:11] free_address
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [9:0] data_address
  logic [1:0]  m_axis_tuser;         // [1:0] status

  first_fit_heap_allocator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow heap: one header per byte offset, as the allocator sees it.
  logic [ffa_pkg::REQ_W-1:0] blk_size   [ffa_pkg::HEAP_BYTES] = '{default: '0};
  ffa_pkg::addr_t            blk_next   [ffa_pkg::HEAP_BYTES] = '{default: '0};
  logic                      blk_linked [ffa_pkg::HEAP_BYTES] = '{default: 1'b0};
  logic                      blk_known  [ffa_pkg::HEAP_BYTES] = '{default: 1'b0};
  ffa_pkg::addr_t            list_head       = '0;
  logic                      list_head_valid = 1'b0;
  logic                      list_tainted    = 1'b0;  // an unwritten header sits on the list
  logic                      walk_hit_limit  = 1'b0;
  ffa_pkg::addr_t            live_blocks[$];

  heap_req_t   requests_to_send[$];
  heap_req_t   req_on_bus = '0;
  heap_reply_t replies_due[$];

  int unsigned n_issued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned n_cmd[4]   = '{default: 0};
  int unsigned n_split = 0, n_whole = 0, n_nofit = 0, n_loops = 0, n_taints = 0;

  int unsigned src_gap    = 0;
  logic        src_burst  = 1'b0;
  int unsigned sink_stall = 0;
  logic        sink_burst = 1'b0;
  int unsigned hold_left  = 0;
  logic        hold_armed = 1'b1;

  function automatic void relink_after(input logic at_head, input ffa_pkg::addr_t prev,
                                       input ffa_pkg::addr_t nxt, input logic nxt_valid);
    if (at_head) begin
      list_head       = nxt;
      list_head_valid = nxt_valid;
    end else begin
      blk_next[prev]   = nxt;
      blk_linked[prev] = nxt_valid;
    end
  endfunction

  // Apply one request to the shadow heap and work out its reply.
  function automatic void heap_apply(input heap_req_t rq, output heap_reply_t rp);
    int unsigned sz, need, cur, prev, steps, split, hofs;
    logic        cur_valid, at_head;
    int          hit[$];
    rp = '{addr: '0, status: ffa_pkg::ST_BAD};
    n_cmd[rq.cmd]++;
    case (rq.cmd)
      ffa_pkg::CMD_INIT: begin
        sz = (rq.size > ffa_pkg::HEAP_BYTES) ? ffa_pkg::HEAP_BYTES : rq.size;
        if (sz > ffa_pkg::HEADER_BYTES) begin
          blk_size[0]     = ffa_pkg::REQ_W'(sz - ffa_pkg::HEADER_BYTES);
          blk_next[0]     = '0;
          blk_linked[0]   = 1'b0;
          blk_known[0]    = 1'b1;
          list_head       = '0;
          list_head_valid = 1'b1;
          list_tainted    = 1'b0;
          walk_hit_limit  = 1'b0;
          live_blocks.delete();
          rp.status = ffa_pkg::ST_OK;
        end
      end
      ffa_pkg::CMD_ALLOC: begin
        if (rq.size != 0) begin
          need      = (rq.size + ffa_pkg::ALIGN_BYTES - 1) / ffa_pkg::ALIGN_BYTES
                    * ffa_pkg::ALIGN_BYTES;
          cur       = list_head;
          cur_valid = list_head_valid;
          at_head   = 1'b1;
          prev      = 0;
          steps     = 0;
          rp.status = ffa_pkg::ST_NOFIT;
          while (cur_valid && steps < ffa_pkg::HEAP_BYTES
                 && rp.status == ffa_pkg::ST_NOFIT) begin
            if (blk_size[cur] >= need) begin
              split = cur + ffa_pkg::HEADER_BYTES + need;
              if (blk_size[cur] > need + ffa_pkg::HEADER_BYTES
                  && split < ffa_pkg::HEAP_BYTES) begin
                blk_size[split]   = ffa_pkg::REQ_W'(blk_size[cur] - need
                                    - ffa_pkg::HEADER_BYTES);
                blk_next[split]   = blk_next[cur];
                blk_linked[split] = blk_linked[cur];
                blk_known[split]  = 1'b1;
                blk_size[cur]     = ffa_pkg::REQ_W'(need);
                relink_after(at_head, ffa_pkg::addr_t'(prev), ffa_pkg::addr_t'(split), 1'b1);
                n_split++;
              end else begin
                relink_after(at_head, ffa_pkg::addr_t'(prev), blk_next[cur], blk_linked[cur]);
                n_whole++;
              end
              rp.addr   = ffa_pkg::addr_t'(cur + ffa_pkg::HEADER_BYTES);
              rp.status = ffa_pkg::ST_OK;
              live_blocks.push_back(rp.addr);
            end else begin
              prev      = cur;
              at_head   = 1'b0;
              cur_valid = blk_linked[cur];
              cur       = blk_next[cur];
              steps++;
            end
          end
          walk_hit_limit = (steps == ffa_pkg::HEAP_BYTES);
          if (walk_hit_limit) n_loops++;
          if (rp.status == ffa_pkg::ST_NOFIT) n_nofit++;
        end
      end
      ffa_pkg::CMD_FREE: begin
        if (rq.faddr >= ffa_pkg::HEADER_BYTES) begin
          hofs = rq.faddr - ffa_pkg::HEADER_BYTES;
          if (hofs < ffa_pkg::HEAP_BYTES) begin
            blk_next[hofs]   = list_head;
            blk_linked[hofs] = list_head_valid;
            if (!blk_known[hofs]) begin
              list_tainted = 1'b1;
              n_taints++;
            end
            list_head       = ffa_pkg::addr_t'(hofs);
            list_head_valid = 1'b1;
            hit = live_blocks.find_first_index(x) with (x == rq.faddr);
            if (hit.size() != 0) live_blocks.delete(hit[0]);
            rp.status = ffa_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Request side: present queued requests, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    heap_req_t   nxt;
    heap_reply_t rp;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        heap_apply(req_on_bus, rp);
        replies_due.push_back(rp);
        n_accepted <= n_accepted + 1;
        src_gap = src_burst ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          src_gap--;
        end else if (requests_to_send.size() != 0) begin
          nxt = requests_to_send.pop_front();
          req_on_bus    <= nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, nxt.faddr, nxt.size};
          s_axis_tuser  <= nxt.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, so the output register fills and the input stalls.
  always @(posedge clk_i or negedge rst_ni) begin : reply_hold
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && n_accepted == HOLD_AT) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Reply side: random stalls, compare every reply against the oldest one due.
  always @(posedge clk_i or negedge rst_ni) begin : reply_monitor
    heap_reply_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          $error("reply with no request outstanding: data_address %0d status %0d",
                 m_axis_tdata[ffa_pkg::ADDR_W-1:0], m_axis_tuser);
          n_errors++;
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tdata[ffa_pkg::ADDR_W-1:0] !== want.addr) begin
            $error("data_address: expected %0d, got %0d", want.addr,
                   m_axis_tdata[ffa_pkg::ADDR_W-1:0]);
            n_errors++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            n_errors++;
          end
        end
        sink_stall = sink_burst ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
      end else if (sink_stall != 0) begin
        sink_stall--;
      end
      m_axis_tready <= (sink_stall == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies still due", cycle_cnt,
               replies_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_request(input logic [ffa_pkg::CMD_W-1:0] cmd, input int unsigned sz,
                               input int unsigned fa);
    requests_to_send.push_back('{cmd: cmd, size: ffa_pkg::REQ_W'(sz),
                                 faddr: ffa_pkg::addr_t'(fa)});
    n_issued++;
  endtask

  // Wait until every queued request has been taken, so the shadow heap is current.
  task automatic settle();
    do @(negedge clk_i); while (n_accepted != n_issued);
  endtask

  function automatic int unsigned alloc_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2)  return 0;
    if (r < 70) return $urandom_range(1, 64);
    if (r < 95) return $urandom_range(65, 400);
    return $urandom_range(401, 2047);
  endfunction

  initial begin : stimulus
    int unsigned roll, ofs, tries;
    logic        found;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty heap, init limits, split and whole takes, bad frees, loops.
    queue_request(ffa_pkg::CMD_ALLOC,  8,    0);
    queue_request(ffa_pkg::CMD_INIT,   0,    0);
    queue_request(ffa_pkg::CMD_INIT,   16,   0);
    queue_request(ffa_pkg::CMD_INIT,   17,   0);
    queue_request(ffa_pkg::CMD_ALLOC,  1,    0);
    queue_request(ffa_pkg::CMD_INIT,   2047, 0);
    queue_request(ffa_pkg::CMD_ALLOC,  0,    0);
    queue_request(ffa_pkg::CMD_ALLOC,  1,    0);
    queue_request(ffa_pkg::CMD_ALLOC,  100,  0);
    queue_request(ffa_pkg::CMD_ALLOC,  2047, 0);
    queue_request(ffa_pkg::CMD_FREE,   0,    16);
    queue_request(ffa_pkg::CMD_ALLOC,  8,    0);
    queue_request(ffa_pkg::CMD_FREE,   0,    0);
    queue_request(ffa_pkg::CMD_FREE,   2047, 15);
    queue_request(CMD_UNUSED,          2047, 1023);
    queue_request(ffa_pkg::CMD_INIT,   1024, 0);
    queue_request(ffa_pkg::CMD_ALLOC,  1008, 0);
    queue_request(ffa_pkg::CMD_ALLOC,  8,    0);
    queue_request(ffa_pkg::CMD_FREE,   0,    16);
    queue_request(ffa_pkg::CMD_FREE,   0,    16);   // self loop on the free list
    queue_request(ffa_pkg::CMD_ALLOC,  2000, 0);
    queue_request(ffa_pkg::CMD_INIT,   1025, 0);
    queue_request(ffa_pkg::CMD_FREE,   0,    1023); // headers never written
    queue_request(ffa_pkg::CMD_FREE,   0,    517);
    queue_request(ffa_pkg::CMD_INIT,   1024, 0);
    queue_request(ffa_pkg::CMD_ALLOC,  992,  0);    // remainder equals one header: take whole
    queue_request(ffa_pkg::CMD_ALLOC,  8,    0);

    for (int k = 0; k < N_RANDOM; k++) begin
      settle();
      if (k == DRAIN_PAUSE) begin
        do @(negedge clk_i); while (replies_due.size() != 0);
      end
      roll = $urandom_range(0, 99);
      if (walk_hit_limit) begin
        queue_request(ffa_pkg::CMD_INIT, $urandom_range(17, 2047), $urandom_range(0, 1023));
      end else if (list_tainted) begin
        // No walks until a good init drops the unwritten header from the list.
        if (roll < 35)
          queue_request(ffa_pkg::CMD_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023));
        else if (roll < 85)
          queue_request(ffa_pkg::CMD_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
        else
          queue_request(CMD_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (roll < 3) begin
        queue_request(ffa_pkg::CMD_INIT,
                      ($urandom_range(0, 1) != 0) ? 1024 : $urandom_range(0, 2047),
                      $urandom_range(0, 1023));
      end else if (roll < 5) begin
        queue_request(CMD_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (roll >= 50 && roll < 85 && live_blocks.size() != 0) begin
        queue_request(ffa_pkg::CMD_FREE, $urandom_range(0, 2047),
                      live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else if (roll >= 85 && roll < 90) begin
        // Free some header that was once written, possibly a second time.
        found = 1'b0;
        ofs   = 0;
        for (tries = 0; tries < 8 && !found; tries++) begin
          ofs   = $urandom_range(0, 125) * ffa_pkg::ALIGN_BYTES;
          found = blk_known[ofs];
        end
        if (found)
          queue_request(ffa_pkg::CMD_FREE, $urandom_range(0, 2047),
                        ofs + ffa_pkg::HEADER_BYTES);
        else
          queue_request(ffa_pkg::CMD_ALLOC, alloc_size(), $urandom_range(0, 1023));
      end else if (roll >= 90 && roll < 93) begin
        queue_request(ffa_pkg::CMD_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else begin
        queue_request(ffa_pkg::CMD_ALLOC, alloc_size(), $urandom_range(0, 1023));
      end
    end

    settle();
    do @(negedge clk_i); while (replies_due.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Checked %0d requests: %0d init, %0d allocate, %0d free, %0d unknown command",
             n_accepted, n_cmd[ffa_pkg::CMD_INIT], n_cmd[ffa_pkg::CMD_ALLOC],
             n_cmd[ffa_pkg::CMD_FREE], n_cmd[CMD_UNUSED]);
    $display("Allocations split %0d, taken whole %0d, no fit %0d (%0d on looping lists); %0d %s",
             n_split, n_whole, n_nofit, n_loops, n_taints,
             "frees of unwritten headers cleared by init");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> first_fit_heap_allocator_top.f
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_hdr_mem.sv
hw/rtl/ffa_sequencer.sv
hw/rtl/ffa_datapath.sv
hw/rtl/first_fit_heap_allocator_top.sv
tb/tb_first_fit_heap_allocator_top.sv
